### design/glj_pkg.sv
package glj_pkg;

   // Field widths
   localparam int WORD_LEN_BITS  = 8;
   localparam int MAX_LINE_WORDS = 1023;
   localparam int COUNT_BITS     = 10;
   localparam int GAP_BITS       = 24;
   localparam int REG_BITS       = 16;
   localparam int SUM_BITS       = 24;

   // Largest number of words an open line may hold
   localparam logic [COUNT_BITS-1:0] WORD_LIMIT =
      COUNT_BITS'((MAX_LINE_WORDS > 1023) ? 1023 : MAX_LINE_WORDS);

   // Divider geometry: dividend covers ideal*n (16+10 bits)
   localparam int NUM_BITS   = REG_BITS + COUNT_BITS;
   localparam int DIV_STEPS  = NUM_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDEAL_SPACE = 1'd1;
   localparam logic [REG_BITS-1:0] LINE_WIDTH_RESET  = 16'd25;
   localparam logic [REG_BITS-1:0] IDEAL_SPACE_RESET = 16'd256;

   // Line close kinds
   localparam logic [1:0] KIND_REDUCED = 2'd0;
   localparam logic [1:0] KIND_WIDENED = 2'd1;
   localparam logic [1:0] KIND_FINAL   = 2'd2;

   typedef struct packed {
      logic [7:0] word_length;
      logic       final_word;
   } glj_req_type;

   typedef struct packed {
      logic [1:0]            close_kind;
      logic [GAP_BITS-1:0]   gap_value;
      logic [COUNT_BITS-1:0] line_word_count;
      logic                  single_word;
      logic                  last_result;
   } glj_rsp_type;

   // One closed line waiting for its gap: gap = add + num / div when do_div
   typedef struct packed {
      logic [1:0]            kind;
      logic                  do_div;
      logic [NUM_BITS-1:0]   num;
      logic [COUNT_BITS-1:0] div;
      logic [REG_BITS-1:0]   add;
      logic [COUNT_BITS-1:0] count;
      logic                  single;
      logic                  last;
   } glj_job_type;

endpackage

### design/glj_front.sv
module glj_front import glj_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  glj_req_type         req_data,
   input  logic [REG_BITS-1:0] line_width,
   input  logic [REG_BITS-1:0] ideal_space,
   output logic                push_valid,
   output glj_job_type         push_job,
   input  logic                push_ready
);

   localparam logic [2:0] FS_IDLE = 3'd0;
   localparam logic [2:0] FS_MUL  = 3'd1;
   localparam logic [2:0] FS_SUM  = 3'd2;
   localparam logic [2:0] FS_PEN  = 3'd3;
   localparam logic [2:0] FS_DEC  = 3'd4;
   localparam logic [2:0] FS_FIN  = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [COUNT_BITS-1:0]    words_ff, words_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [WORD_LEN_BITS-1:0] word_ff, word_in;
   logic                     fin_ff, fin_in;
   logic [NUM_BITS-1:0]      prod_ff, prod_in;
   logic [33:0]              prev8_ff, prev8_in;
   logic [33:0]              spaced8_ff, spaced8_in;
   logic signed [34:0]       slack_ff, slack_in;
   logic signed [34:0]       red_ff, red_in;

   logic [34:0]   pen_amp, pen_red;
   logic          over, full, reduce, n_zero, slack_pos, need, advance;
   logic [SUM_BITS:0] sum_add;
   logic [SUM_BITS-1:0] sum_sat;
   glj_job_type   job;

   assign req_ready = (state_ff == FS_IDLE);

   // Penalties and break decision
   always_comb begin
      n_zero    = (words_ff == '0);
      full      = (words_ff >= WORD_LIMIT);
      over      = !red_ff[34] && (red_ff != '0);
      slack_pos = !slack_ff[34] && (slack_ff != '0);
      pen_amp   = slack_ff[34] ? 35'(-slack_ff) : 35'(slack_ff);
      pen_red   = over ? 35'(red_ff) : '0;
      reduce    = !full && over && (pen_amp > pen_red) && (35'(prod_ff) > pen_red);
      sum_add   = {1'b0, sum_ff} + (SUM_BITS+1)'(word_ff);
      sum_sat   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
   end

   // Sequencer, state update and job build
   always_comb begin
      state_in   = state_ff;
      words_in   = words_ff;
      sum_in     = sum_ff;
      word_in    = word_ff;
      fin_in     = fin_ff;
      prod_in    = prod_ff;
      prev8_in   = prev8_ff;
      spaced8_in = spaced8_ff;
      slack_in   = slack_ff;
      red_in     = red_ff;
      job        = '0;
      need       = 1'b0;
      advance    = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               word_in  = req_data.word_length[WORD_LEN_BITS-1:0];
               fin_in   = req_data.final_word;
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            prod_in  = {{COUNT_BITS{1'b0}}, ideal_space} * {{REG_BITS{1'b0}}, words_ff};
            state_in = FS_SUM;
         end
         FS_SUM: begin
            prev8_in   = 34'({sum_ff, 8'b0}) + 34'(prod_ff) - 34'(ideal_space);
            spaced8_in = 34'({sum_ff, 8'b0}) + 34'(prod_ff) + 34'({word_ff, 8'b0});
            state_in   = FS_PEN;
         end
         FS_PEN: begin
            slack_in = $signed(35'({line_width, 8'b0})) - $signed({1'b0, prev8_ff});
            red_in   = $signed({1'b0, spaced8_ff}) - $signed(35'({line_width, 8'b0}));
            state_in = FS_DEC;
         end
         FS_DEC: begin
            priority if (n_zero) begin
               // lone word opens a line
               need       = fin_ff;
               job.kind   = KIND_FINAL;
               job.count  = COUNT_BITS'(1);
               job.last   = 1'b1;
               advance    = !need || push_ready;
               if (advance) begin
                  words_in = fin_ff ? '0 : COUNT_BITS'(1);
                  sum_in   = fin_ff ? '0 : SUM_BITS'(word_ff);
                  state_in = FS_IDLE;
               end
            end else if ((over || full) && reduce) begin
               // close with the word, reduced gap
               need       = 1'b1;
               job.kind   = KIND_REDUCED;
               job.do_div = 1'b1;
               job.num    = prod_ff - pen_red[NUM_BITS-1:0];
               job.div    = words_ff;
               job.count  = words_ff + COUNT_BITS'(1);
               job.last   = 1'b1;
               advance    = push_ready;
               if (advance) begin
                  words_in = '0;
                  sum_in   = '0;
                  state_in = FS_IDLE;
               end
            end else if (over || full) begin
               // close before the word, widened gap
               need      = 1'b1;
               job.kind  = KIND_WIDENED;
               job.count = words_ff;
               job.last  = !fin_ff;
               if (words_ff >= COUNT_BITS'(2)) begin
                  job.do_div = 1'b1;
                  job.num    = slack_pos ? NUM_BITS'(slack_ff[GAP_BITS-1:0]) : '0;
                  job.div    = words_ff - COUNT_BITS'(1);
                  job.add    = ideal_space;
               end else begin
                  job.single = 1'b1;
               end
               advance = push_ready;
               if (advance) begin
                  words_in = COUNT_BITS'(1);
                  sum_in   = SUM_BITS'(word_ff);
                  state_in = fin_ff ? FS_FIN : FS_IDLE;
               end
            end else begin
               // word fits: extend the line
               need      = fin_ff;
               job.kind  = KIND_FINAL;
               job.count = words_ff + COUNT_BITS'(1);
               job.last  = 1'b1;
               advance   = !need || push_ready;
               if (advance) begin
                  words_in = fin_ff ? '0 : words_ff + COUNT_BITS'(1);
                  sum_in   = fin_ff ? '0 : sum_sat;
                  state_in = FS_IDLE;
               end
            end
         end
         FS_FIN: begin
            // closing word as its own final line
            need      = 1'b1;
            job.kind  = KIND_FINAL;
            job.count = COUNT_BITS'(1);
            job.last  = 1'b1;
            if (push_ready) begin
               words_in = '0;
               sum_in   = '0;
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   assign push_valid = need;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         words_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         words_ff <= words_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      fin_ff     <= fin_in;
      prod_ff    <= prod_in;
      prev8_ff   <= prev8_in;
      spaced8_ff <= spaced8_in;
      slack_ff   <= slack_in;
      red_ff     <= red_in;
   end

endmodule

### design/glj_queue.sv
module glj_queue import glj_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  glj_job_type push_job,
   output logic        pop_valid,
   input  logic        pop_ready,
   output glj_job_type pop_job
);

   glj_job_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/glj_back.sv
module glj_back import glj_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  glj_job_type pop_job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output glj_rsp_type rsp_data
);

   localparam logic [1:0] BS_IDLE = 2'd0;
   localparam logic [1:0] BS_DIV  = 2'd1;
   localparam logic [1:0] BS_OUT  = 2'd2;

   logic [1:0]            state_ff, state_in;
   glj_job_type           job_ff, job_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   glj_rsp_type           rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS:0]   rem_sh;
   logic                  ge;
   logic [NUM_BITS:0]     gap_sum;
   logic [GAP_BITS-1:0]   gap;
   logic                  out_free;

   assign pop_ready = (state_ff == BS_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // One quotient bit per cycle, restoring
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_BITS-1]};
      ge     = (rem_sh >= {1'b0, job_ff.div});
   end

   // Gap assembly with saturation
   always_comb begin
      gap_sum = (NUM_BITS+1)'(job_ff.add) + (NUM_BITS+1)'(quo_ff);
      if (!job_ff.do_div) begin
         gap = '0;
      end else if (gap_sum[NUM_BITS:GAP_BITS] != '0) begin
         gap = '1;
      end else begin
         gap = gap_sum[GAP_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         BS_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_job;
               quo_in   = pop_job.num;
               rem_in   = '0;
               step_in  = '0;
               state_in = pop_job.do_div ? BS_DIV : BS_OUT;
            end
         end
         BS_DIV: begin
            rem_in  = ge ? COUNT_BITS'(rem_sh - {1'b0, job_ff.div}) : rem_sh[COUNT_BITS-1:0];
            quo_in  = {quo_ff[NUM_BITS-2:0], ge};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = BS_OUT;
            end
         end
         BS_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.close_kind      = job_ff.kind;
               rsp_data_in.gap_value       = gap;
               rsp_data_in.line_word_count = job_ff.count;
               rsp_data_in.single_word     = job_ff.single;
               rsp_data_in.last_result     = job_ff.last;
               state_in                    = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/greedy_line_justifier.sv
// Greedy line justifier.
// Word lengths enter on the req_ channel (valid/ready), one word per item,
// with final_word set on the last word of a paragraph. Closed lines leave on
// the rsp_ channel (valid/ready): kind, adjusted Q16.8 gap, word count, a
// one-word flag and a mark on the last result of each input item.
// line_width and ideal_space are written through csr_wr_en/csr_index/
// csr_wr_data; the user must write them only while the block is idle (the
// block does not enforce this). Reset loads 25 and 1.0 (Q8.8). The front
// steps each item through IDLE, MUL, SUM, PEN and DEC (and FIN when a
// widened line and a final line both close), working the break decision
// through its multiplier and adders. Closed lines wait in a 4-entry job
// queue. The back computes each gap with a shared restoring divider, one
// quotient bit per cycle, when the gap needs a division; a final or one-word
// line skips it. A word that only extends the open line yields no result.
// A stalled rsp_ready holds the output register; the back, then the queue
// and then the front stall behind it. Reset empties the queue, drops any
// pending result and clears the open line.
module greedy_line_justifier import glj_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  glj_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output glj_rsp_type               rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wr_data
);

   logic [REG_BITS-1:0] line_width_ff, line_width_in;
   logic [REG_BITS-1:0] ideal_space_ff, ideal_space_in;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   glj_job_type push_job, pop_job;

   // Configuration registers
   always_comb begin
      line_width_in  = line_width_ff;
      ideal_space_in = ideal_space_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:  line_width_in  = csr_wr_data;
            CSR_IDEAL_SPACE: ideal_space_in = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RESET;
         ideal_space_ff <= IDEAL_SPACE_RESET;
      end else begin
         line_width_ff  <= line_width_in;
         ideal_space_ff <= ideal_space_in;
      end
   end

   glj_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .line_width  (line_width_ff),
      .ideal_space (ideal_space_ff),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_ready  (push_ready)
   );

   glj_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   glj_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/glj_checker.sv
module glj_checker import glj_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input glj_rsp_type rsp_data
);

   // Stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed or dropped while stalled");

   // Final line carries no gap and ends its input's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.close_kind == KIND_FINAL) |->
         (rsp_data.gap_value == '0) && !rsp_data.single_word && rsp_data.last_result)
      else $error("bad final line item");

   // Reduced line always includes the word and ends its input's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.close_kind == KIND_REDUCED) |->
         rsp_data.last_result && !rsp_data.single_word &&
         (rsp_data.line_word_count >= COUNT_BITS'(2)))
      else $error("bad reduced line item");

   // One-word flag only on a widened one-word line with zero gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.single_word |->
         (rsp_data.close_kind == KIND_WIDENED) && (rsp_data.gap_value == '0) &&
         (rsp_data.line_word_count == COUNT_BITS'(1)))
      else $error("bad one-word line item");

endmodule

bind greedy_line_justifier glj_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
